// ===== rtl/vspt_pkg.sv =====
// ----------------------------------------------------------------------------
// vspt_pkg
// Shared types, constants and tables for the vertex set pivot transform core.
// ----------------------------------------------------------------------------
package vspt_pkg;

	localparam int MAX_VERTICES_DEF = 8;
	localparam int COORD_BITS_DEF   = 24;

	localparam int FIELD_W    = 24;
	localparam int CMD_W      = 3;
	localparam int IDX_W      = 3;
	localparam int DIR_W      = 2;
	localparam int ANG_W      = 16;
	localparam int CNT_W      = 4;
	localparam int FACT_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TRANSLATE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ZOOM_IN   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ZOOM_OUT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROTATE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIVOT_INDEX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM_IN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM_OUT     = 3'd4;

	localparam logic [CNT_W-1:0]  RST_VERTEX_COUNT = 4'd7;
	localparam logic [IDX_W-1:0]  RST_PIVOT_INDEX  = 3'd1;
	localparam logic [FACT_W-1:0] RST_STEP_SIZE    = 16'd2560;
	localparam logic [FACT_W-1:0] RST_ZOOM_IN      = 16'd17203;
	localparam logic [FACT_W-1:0] RST_ZOOM_OUT     = 16'd15565;

	// CORDIC datapath widths and Q16 angle constants.
	localparam int CORD_W     = 20;
	localparam int CORD_ZW    = 22;
	localparam int CS_W       = 18;
	localparam int CORD_ITERS = 16;
	localparam logic signed [CORD_ZW-1:0] TWO_PI_Q16  = 22'sd411775;
	localparam logic signed [CORD_ZW-1:0] PI_Q16      = 22'sd205887;
	localparam logic signed [CORD_ZW-1:0] HALF_PI_Q16 = 22'sd102944;
	localparam logic signed [CORD_W-1:0]  CORDIC_GAIN = 20'sd39797;

	localparam logic [2:0] MUL_LAST = 3'd4;

	function automatic logic signed [CORD_ZW-1:0] atan_q16(input logic [3:0] i);
		logic signed [CORD_ZW-1:0] r;
		case (i)
			4'd0:  r = 22'sd51472;
			4'd1:  r = 22'sd30386;
			4'd2:  r = 22'sd16055;
			4'd3:  r = 22'sd8150;
			4'd4:  r = 22'sd4091;
			4'd5:  r = 22'sd2047;
			4'd6:  r = 22'sd1024;
			4'd7:  r = 22'sd512;
			4'd8:  r = 22'sd256;
			4'd9:  r = 22'sd128;
			4'd10: r = 22'sd64;
			4'd11: r = 22'sd32;
			4'd12: r = 22'sd16;
			4'd13: r = 22'sd8;
			4'd14: r = 22'sd4;
			default: r = 22'sd2;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic [IDX_W-1:0]          vertex_index;
		logic signed [FIELD_W-1:0] load_x;
		logic signed [FIELD_W-1:0] load_y;
		logic [FIELD_W-1:0]        load_radius;
		logic [DIR_W-1:0]          direction;
		logic signed [ANG_W-1:0]   angle;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]          out_index;
		logic signed [FIELD_W-1:0] out_x;
		logic signed [FIELD_W-1:0] out_y;
		logic [FIELD_W-1:0]        out_radius;
		logic                      last;
	} out_item_t;

	typedef struct packed {
		logic       latch_in;
		logic       load_wr;
		logic       rd_read;
		logic       rd_pivot;
		logic       rd_vertex;
		logic       cap_pivot;
		logic       cap_vertex;
		logic       cordic_start;
		logic       mul_en;
		logic [2:0] mul_k;
		logic       vtx_wr;
		logic       emit_read;
		logic       clr_i;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             n_zero;
		logic             last_vertex;
		logic             cordic_busy;
		logic             out_free;
	} dp_stat_t;

endpackage

// ===== rtl/vspt_cordic.sv =====
// ----------------------------------------------------------------------------
// vspt_cordic
// Iterative CORDIC that turns a rotation angle into cosine and sine in Q16.
// ----------------------------------------------------------------------------
module vspt_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [vspt_pkg::ANG_W-1:0]     angle,
	output logic signed [vspt_pkg::CS_W-1:0]      cos_o,
	output logic signed [vspt_pkg::CS_W-1:0]      sin_o,
	output logic                                  busy
);
	import vspt_pkg::*;

	logic signed [CORD_ZW-1:0] z0, z1, z2;
	logic                      neg0;
	logic signed [CORD_W-1:0]  x_q, y_q, xs, ys;
	logic signed [CORD_ZW-1:0] z_q;
	logic [3:0]                it_q;
	logic                      busy_q, neg_q;

	// Range reduction: wrap into [-pi, pi], then fold into [-pi/2, pi/2].
	always_comb begin
		z0 = CORD_ZW'(angle) <<< 4;
		if (z0 > PI_Q16)
			z1 = z0 - TWO_PI_Q16;
		else if (z0 < -PI_Q16)
			z1 = z0 + TWO_PI_Q16;
		else
			z1 = z0;
		neg0 = 1'b0;
		z2   = z1;
		if (z1 > HALF_PI_Q16) begin
			z2   = z1 - PI_Q16;
			neg0 = 1'b1;
		end else if (z1 < -HALF_PI_Q16) begin
			z2   = z1 + PI_Q16;
			neg0 = 1'b1;
		end
	end

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			it_q   <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 4'd1;
			if (it_q == 4'(CORD_ITERS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z2;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16(it_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16(it_q);
			end
		end
	end

	assign cos_o = neg_q ? CS_W'(-x_q) : CS_W'(x_q);
	assign sin_o = neg_q ? CS_W'(-y_q) : CS_W'(y_q);
	assign busy  = busy_q;

endmodule

// ===== rtl/vspt_dp.sv =====
// ----------------------------------------------------------------------------
// vspt_dp
// Datapath: configuration registers, vertex store, shared multiplier,
// saturation and the result register.
// ----------------------------------------------------------------------------
module vspt_dp #(
	parameter int MAX_VERTICES = vspt_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = vspt_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vspt_pkg::in_item_t                 in_item,
	input  logic                               cfg_we,
	input  logic [vspt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vspt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  vspt_pkg::dp_cmd_t                  cmd,
	output vspt_pkg::dp_stat_t                 stat,
	output vspt_pkg::out_item_t                out_item,
	output logic                               out_valid,
	input  logic                               out_ready
);
	import vspt_pkg::*;

	localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW   = COORD_BITS;
	localparam int DW   = CW + 1;
	localparam int PW   = DW + CS_W;
	localparam int ACCW = PW + 1;
	localparam int SW   = ACCW + 1;

	localparam logic signed [SW-1:0] CMAX  = (SW'(1) <<< (CW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] CMIN  = -CMAX - SW'(1);
	localparam logic signed [SW-1:0] RMAX  = (SW'(1) <<< CW) - SW'(1);
	localparam logic signed [SW-1:0] RND14 = SW'(8192);
	localparam logic signed [SW-1:0] RND16 = SW'(32768);

	function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > CMAX)
			r = CMAX[CW-1:0];
		else if (v < CMIN)
			r = CMIN[CW-1:0];
		else
			r = v[CW-1:0];
		return r;
	endfunction

	function automatic logic [CW-1:0] sat_r(input logic signed [SW-1:0] v);
		logic [CW-1:0] r;
		if (v > RMAX)
			r = RMAX[CW-1:0];
		else if (v < 0)
			r = '0;
		else
			r = v[CW-1:0];
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] out_c(input logic signed [CW-1:0] v);
		logic signed [SW-1:0] t;
		t = SW'(v);
		return t[FIELD_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] out_r(input logic [CW-1:0] v);
		logic [SW-1:0] t;
		t = SW'(v);
		return t[FIELD_W-1:0];
	endfunction

	// Configuration registers.
	logic [CNT_W-1:0]  vc_q;
	logic [IDX_W-1:0]  piv_q;
	logic [FACT_W-1:0] step_q, zin_q, zout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q   <= RST_VERTEX_COUNT;
			piv_q  <= RST_PIVOT_INDEX;
			step_q <= RST_STEP_SIZE;
			zin_q  <= RST_ZOOM_IN;
			zout_q <= RST_ZOOM_OUT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vc_q   <= cfg_wdata[CNT_W-1:0];
				REG_PIVOT_INDEX:  piv_q  <= cfg_wdata[IDX_W-1:0];
				REG_STEP_SIZE:    step_q <= cfg_wdata;
				REG_ZOOM_IN:      zin_q  <= cfg_wdata;
				REG_ZOOM_OUT:     zout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0] n_c, i_q;
	logic             idx_ok, piv_ok, rot;
	in_item_t         in_q;

	assign n_c    = (int'(vc_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vc_q;
	assign idx_ok = int'(in_q.vertex_index) < MAX_VERTICES;
	assign piv_ok = int'(piv_q) < MAX_VERTICES;
	assign rot    = (in_q.cmd == CMD_ROTATE);

	always_ff @(posedge clk) begin
		if (cmd.latch_in)
			in_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			i_q <= '0;
		else if (cmd.clr_i)
			i_q <= '0;
		else if (cmd.vtx_wr)
			i_q <= i_q + CNT_W'(1);
	end

	// Vertex store: {x, y, radius} per entry. Entries never written read as zero.
	logic [3*CW-1:0]         mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] vld_q;
	logic [3*CW-1:0]         rd_q, wr_data;
	logic                    rd_vld_q, rd_en, wr_en;
	logic [AW-1:0]           rd_addr, wr_addr;

	assign rd_en   = (cmd.rd_read & idx_ok) | (cmd.rd_pivot & piv_ok) | cmd.rd_vertex;
	assign rd_addr = cmd.rd_pivot  ? AW'(piv_q) :
	                 cmd.rd_vertex ? AW'(i_q) : AW'(in_q.vertex_index);
	assign wr_en   = (cmd.load_wr & idx_ok) | cmd.vtx_wr;
	assign wr_addr = cmd.load_wr ? AW'(in_q.vertex_index) : AW'(i_q);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	logic signed [CW-1:0] rd_x, rd_y;
	logic [CW-1:0]        rd_r;

	assign rd_x = rd_vld_q ? rd_q[3*CW-1:2*CW] : '0;
	assign rd_y = rd_vld_q ? rd_q[2*CW-1:CW]   : '0;
	assign rd_r = rd_vld_q ? rd_q[CW-1:0]      : '0;

	// Pivot and current vertex operands.
	logic signed [CW-1:0] px_q, py_q, cx_q, cy_q;
	logic [CW-1:0]        cr_q;
	logic signed [DW-1:0] dx_q, dy_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_pivot) begin
			px_q <= piv_ok ? rd_x : '0;
			py_q <= piv_ok ? rd_y : '0;
		end
		if (cmd.cap_vertex) begin
			cx_q <= rd_x;
			cy_q <= rd_y;
			cr_q <= rd_r;
			dx_q <= DW'(rd_x) - DW'(px_q);
			dy_q <= DW'(rd_y) - DW'(py_q);
		end
	end

	logic signed [CS_W-1:0] cos_c, sin_c, fac_s;
	logic                   cordic_busy;

	vspt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cordic_start),
		.angle  (in_q.angle),
		.cos_o  (cos_c),
		.sin_o  (sin_c),
		.busy   (cordic_busy)
	);

	assign fac_s = (in_q.cmd == CMD_ZOOM_IN) ? {{(CS_W-FACT_W){1'b0}}, zin_q}
	                                         : {{(CS_W-FACT_W){1'b0}}, zout_q};

	// Shared multiplier; each product is registered and folded in on the next step.
	logic signed [DW-1:0]   mul_a, r_s;
	logic signed [CS_W-1:0] mul_b;
	logic signed [PW-1:0]   prod_q;
	logic signed [ACCW-1:0] acc_x_q, acc_y_q, acc_r_q;

	assign r_s = {1'b0, cr_q};

	always_comb begin
		mul_a = dx_q;
		mul_b = rot ? cos_c : fac_s;
		if (rot) begin
			case (cmd.mul_k)
				3'd0: begin mul_a = dx_q; mul_b = cos_c; end
				3'd1: begin mul_a = dy_q; mul_b = sin_c; end
				3'd2: begin mul_a = dx_q; mul_b = sin_c; end
				3'd3: begin mul_a = dy_q; mul_b = cos_c; end
				default: ;
			endcase
		end else begin
			case (cmd.mul_k)
				3'd0: mul_a = dx_q;
				3'd1: mul_a = dy_q;
				3'd2: mul_a = r_s;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
			if (rot) begin
				case (cmd.mul_k)
					3'd1: acc_x_q <= ACCW'(prod_q);
					3'd2: acc_x_q <= acc_x_q - ACCW'(prod_q);
					3'd3: acc_y_q <= ACCW'(prod_q);
					3'd4: acc_y_q <= acc_y_q + ACCW'(prod_q);
					default: ;
				endcase
			end else begin
				case (cmd.mul_k)
					3'd1: acc_x_q <= ACCW'(prod_q);
					3'd2: acc_y_q <= ACCW'(prod_q);
					3'd3: acc_r_q <= ACCW'(prod_q);
					default: ;
				endcase
			end
		end
	end

	// New vertex values.
	logic signed [SW-1:0] step_s, px_s, py_s, cx_s, cy_s, ax_s, ay_s, ar_s;
	logic signed [SW-1:0] ld_x_s, ld_y_s, ld_r_s;
	logic signed [CW-1:0] nx, ny;
	logic [CW-1:0]        nr;

	assign step_s = SW'(step_q);
	assign px_s   = SW'(px_q);
	assign py_s   = SW'(py_q);
	assign cx_s   = SW'(cx_q);
	assign cy_s   = SW'(cy_q);
	assign ax_s   = SW'(acc_x_q);
	assign ay_s   = SW'(acc_y_q);
	assign ar_s   = SW'(acc_r_q);
	assign ld_x_s = SW'(in_q.load_x);
	assign ld_y_s = SW'(in_q.load_y);
	assign ld_r_s = SW'(in_q.load_radius);

	always_comb begin
		nx = cx_q;
		ny = cy_q;
		nr = cr_q;
		if (in_q.cmd == CMD_TRANSLATE) begin
			case (in_q.direction)
				DIR_UP:    ny = sat_c(cy_s + step_s);
				DIR_LEFT:  nx = sat_c(cx_s - step_s);
				DIR_DOWN:  ny = sat_c(cy_s - step_s);
				DIR_RIGHT: nx = sat_c(cx_s + step_s);
				default: ;
			endcase
		end else if (rot) begin
			nx = sat_c(px_s + ((ax_s + RND16) >>> 16));
			ny = sat_c(py_s + ((ay_s + RND16) >>> 16));
		end else begin
			nx = sat_c(px_s + ((ax_s + RND14) >>> 14));
			ny = sat_c(py_s + ((ay_s + RND14) >>> 14));
			nr = sat_r((ar_s + RND14) >>> 14);
		end
	end

	assign wr_data = cmd.load_wr ? {sat_c(ld_x_s), sat_c(ld_y_s), sat_r(ld_r_s)}
	                             : {nx, ny, nr};

	// Result register.
	logic      out_valid_q, emit, last_vertex;
	out_item_t out_q;

	assign emit        = cmd.emit_read | cmd.vtx_wr;
	assign last_vertex = (i_q == n_c - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_read) begin
			out_q.out_index  <= in_q.vertex_index;
			out_q.out_x      <= idx_ok ? out_c(rd_x) : '0;
			out_q.out_y      <= idx_ok ? out_c(rd_y) : '0;
			out_q.out_radius <= idx_ok ? out_r(rd_r) : '0;
			out_q.last       <= 1'b1;
		end else if (cmd.vtx_wr) begin
			out_q.out_index  <= i_q[IDX_W-1:0];
			out_q.out_x      <= out_c(nx);
			out_q.out_y      <= out_c(ny);
			out_q.out_radius <= out_r(nr);
			out_q.last       <= last_vertex;
		end
	end

	assign out_item         = out_q;
	assign out_valid        = out_valid_q;
	assign stat.cmd         = in_q.cmd;
	assign stat.n_zero      = (n_c == '0);
	assign stat.last_vertex = last_vertex;
	assign stat.cordic_busy = cordic_busy;
	assign stat.out_free    = !out_valid_q || out_ready;

endmodule

// ===== rtl/vspt_ctrl.sv =====
// ----------------------------------------------------------------------------
// vspt_ctrl
// Command sequencer: decodes each transaction and steps the datapath through
// loads, reads and per-vertex transform passes.
// ----------------------------------------------------------------------------
module vspt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [vspt_pkg::CMD_W-1:0]     in_cmd,
	output logic                           in_ready,
	input  vspt_pkg::dp_stat_t             stat,
	output vspt_pkg::dp_cmd_t              cmd
);
	import vspt_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_LOAD   = 11'b00000000010,
		S_RADDR  = 11'b00000000100,
		S_REMIT  = 11'b00000001000,
		S_PADDR  = 11'b00000010000,
		S_PWAIT  = 11'b00000100000,
		S_CORDIC = 11'b00001000000,
		S_VADDR  = 11'b00010000000,
		S_VWAIT  = 11'b00100000000,
		S_MUL    = 11'b01000000000,
		S_VWR    = 11'b10000000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] mstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mstep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_VWAIT)
				mstep_q <= '0;
			else if (state_q == S_MUL)
				mstep_q <= mstep_q + 3'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_k = mstep_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					cmd.clr_i    = 1'b1;
					if (in_cmd == CMD_LOAD)
						state_d = S_LOAD;
					else if (in_cmd == CMD_READ)
						state_d = S_RADDR;
					else if (in_cmd inside {CMD_TRANSLATE, CMD_ZOOM_IN, CMD_ZOOM_OUT,
					                        CMD_ROTATE} && !stat.n_zero)
						state_d = S_PADDR;
				end
			end
			S_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_RADDR: begin
				cmd.rd_read = 1'b1;
				state_d     = S_REMIT;
			end
			S_REMIT: begin
				if (stat.out_free) begin
					cmd.emit_read = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_PADDR: begin
				cmd.rd_pivot = 1'b1;
				state_d      = S_PWAIT;
			end
			S_PWAIT: begin
				cmd.cap_pivot = 1'b1;
				if (stat.cmd == CMD_ROTATE) begin
					cmd.cordic_start = 1'b1;
					state_d          = S_CORDIC;
				end else begin
					state_d = S_VADDR;
				end
			end
			S_CORDIC: begin
				if (!stat.cordic_busy)
					state_d = S_VADDR;
			end
			S_VADDR: begin
				cmd.rd_vertex = 1'b1;
				state_d       = S_VWAIT;
			end
			S_VWAIT: begin
				cmd.cap_vertex = 1'b1;
				state_d = (stat.cmd == CMD_TRANSLATE) ? S_VWR : S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (mstep_q == MUL_LAST)
					state_d = S_VWR;
			end
			S_VWR: begin
				if (stat.out_free) begin
					cmd.vtx_wr = 1'b1;
					state_d    = stat.last_vertex ? S_IDLE : S_VADDR;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ===== rtl/vertex_set_pivot_transform_core.sv =====
// A load writes one vertex store entry; a read fetches an entry and emits it as
// one result. A transform reads the pivot (and runs the sine/cosine CORDIC for
// rotate), then per vertex reads, multiplies (zoom/rotate only) and writes back.
// Throughput: one transaction at a time, one result per vertex; the single
// shared multiplier and the vertex store set the per-vertex cost. Reset (arst_n,
// async low) clears the vertex store to zero and loads the register defaults.
// ----------------------------------------------------------------------------
// vertex_set_pivot_transform_core
// Vertex set with translate, zoom and rotate about a pivot vertex.
// ----------------------------------------------------------------------------
module vertex_set_pivot_transform_core #(
	parameter int MAX_VERTICES = vspt_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = vspt_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  vspt_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output vspt_pkg::out_item_t             result,
	input  logic                            cfg_we,
	input  logic [vspt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vspt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import vspt_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	vspt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_valid),
		.in_cmd   (item.cmd),
		.in_ready (item_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	vspt_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.out_item  (result),
		.out_valid (result_valid),
		.out_ready (result_ready)
	);

endmodule

// ===== rtl/vspt_checker.sv =====
// ----------------------------------------------------------------------------
// vspt_checker
// Port-level checks on the vertex set pivot transform core.
// ----------------------------------------------------------------------------
module vspt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_ready,
	input vspt_pkg::in_item_t              item,
	input logic                            result_valid,
	input logic                            result_ready,
	input vspt_pkg::out_item_t             result,
	input logic                            cfg_we,
	input logic [vspt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [vspt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import vspt_pkg::*;

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// A load transaction into an empty output produces no result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.cmd == CMD_LOAD && !result_valid
		|=> !result_valid)
		else $error("load produced a result");

	// A read keeps the block busy until its result is formed.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.cmd == CMD_READ |=> !item_ready)
		else $error("read accepted back to back");

	// No new transaction is taken while a transform is still emitting.
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> !item_ready)
		else $error("transaction accepted during a result burst");

endmodule

bind vertex_set_pivot_transform_core vspt_checker u_vspt_checker (.*);
